// ===== rtl/grid_ray_traversal_defines.svh =====
// Assertion macros for the checker module of the ray walker.
`ifndef GRID_RAY_TRAVERSAL_DEFINES_SVH
`define GRID_RAY_TRAVERSAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid_ray_traversal: check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid_ray_traversal: check failed");

`endif

// ===== rtl/grt_pkg.sv =====
package grt_pkg;

  localparam int FracBits = 16;
  localparam int CellBits = 16;
  localparam int DivNumW  = 2 * FracBits + 1;
  localparam int DivCntW  = $clog2(DivNumW + 1);
  localparam int SqrtSteps = 32;
  localparam int SqrtCntW = $clog2(SqrtSteps + 1);

  localparam logic [31:0] Never = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_START,
    OP_ADVANCE
  } op_e;

  typedef enum logic [1:0] {
    EDGE_TOP,
    EDGE_RIGHT,
    EDGE_BOTTOM,
    EDGE_LEFT
  } edge_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_POS,
    ST_SQA,
    ST_SQB,
    ST_SUM,
    ST_SQRT,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [31:0]        den;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [1:0]  edge_res;
    logic [15:0] offset;
    logic [31:0] distance;
    logic        no_hit;
  } result_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] time_add(logic [31:0] t, logic [31:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {1'b0, d};
    if (t == Never || s >= {1'b0, Never}) return Never;
    return s[31:0];
  endfunction

  // Fraction of a coordinate rescaled to sixteen bits.
  function automatic logic [15:0] frac_off(logic [31:0] p);
    logic [47:0] w;
    w = 48'(p[FracBits-1:0]) << 16;
    return w[FracBits +: 16];
  endfunction

  function automatic logic [31:0] abs_diff(logic [31:0] x, logic [31:0] y);
    logic [32:0] d;
    d = {x[31], x} - {y[31], y};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

endpackage

// ===== rtl/grt_front.sv =====
module grt_front import grt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               item_pop_i
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Each word is tagged with its operation as it enters the queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].op       <= mode_i ? OP_ADVANCE : OP_START;
      fifo_q[wr_ptr_q].origin_x <= origin_x_i;
      fifo_q[wr_ptr_q].origin_y <= origin_y_i;
      fifo_q[wr_ptr_q].dir_x    <= dir_x_i;
      fifo_q[wr_ptr_q].dir_y    <= dir_y_i;
    end
  end

endmodule

// ===== rtl/grt_div.sv =====
module grt_div import grt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [DivNumW-1:0] num_q, quo_q;
  logic [31:0]        rem_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [32:0]        rem_sh, rem_nx;
  logic               ge;
  logic [63:0]        quo_wide;

  assign rem_sh   = {rem_q, num_q[DivNumW-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_nx   = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign quo_wide = 64'(quo_q);
  assign done_o   = done_q;
  // A zero divisor or a quotient that reaches all ones means the axis never crosses.
  assign quo_o    = (den_q == '0 || quo_wide >= 64'(Never)) ? Never : quo_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_nx[31:0];
      quo_q <= {quo_q[DivNumW-2:0], ge};
    end
  end

endmodule

// ===== rtl/grt_sqrt.sv =====
module grt_sqrt import grt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqrt_req_t   req_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0]         rem_q, root_q, bit_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic                busy_q, done_q;
  logic [63:0]         trial;
  logic                take;

  assign trial  = root_q + bit_q;
  assign take   = rem_q >= trial;
  assign done_o = done_q;
  assign root_o = root_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= SqrtCntW'(SqrtSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SqrtCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One result bit per cycle, two radicand bits consumed per step.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.radicand;
      root_q <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (take) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== rtl/grt_back.sv =====
module grt_back import grt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  state_e state_q, state_d;

  logic [31:0]         org_x_q, org_y_q, dir_x_q, dir_y_q;
  logic [31:0]         tnx_q, tny_q, tix_q, tiy_q;
  logic [CellBits-1:0] cell_x_q, cell_y_q;
  logic [1:0]          sgn_x_q, sgn_y_q;
  logic [1:0]          div_idx_q;
  logic                vert_q;
  logic [63:0]         prod_q, a2_q;
  logic [31:0]         a_q, b_q;
  result_t             res_q, out_q;
  logic                out_valid_q;

  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_quo;
  sqrt_req_t   sqrt_req;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  logic        both_never, x_first, out_load;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] sq_sum;

  // Division operands for the current time being set up.
  logic [31:0]         div_dir, div_org;
  logic [1:0]          div_sgn;
  logic [FracBits:0]   gap;

  // Hit position terms.
  logic [31:0]         p_oth, v_oth, h_oth, h_crs, hx, hy;
  logic [63-FracBits:0] d_oth;
  logic [65:0]         p_ext, d_ext;
  logic [CellBits-1:0] c_crs, c_step;
  logic [1:0]          s_crs;
  logic [CellBits:0]   c_inc;
  logic                inc;
  logic [65:0]         crs_wide;

  grt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  grt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  assign both_never  = (tnx_q == Never) && (tny_q == Never);
  assign x_first     = tnx_q < tny_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign sq_sum      = {1'b0, a2_q} + {1'b0, prod_q};

  // Divisions run in the order: x interval, x first time, y interval, y first time.
  assign div_dir = div_idx_q[1] ? dir_y_q : dir_x_q;
  assign div_org = div_idx_q[1] ? org_y_q : org_x_q;
  assign div_sgn = div_idx_q[1] ? sgn_y_q : sgn_x_q;
  assign gap     = (div_sgn == 2'b01) ?
                   (FracBits+1)'(1 << FracBits) - (FracBits+1)'(div_org[FracBits-1:0]) :
                   (FracBits+1)'(div_org[FracBits-1:0]);

  always_comb begin
    div_req.start = (state_q == ST_DIV_GO);
    div_req.den   = mag32(div_dir);
    if (div_idx_q[0]) div_req.num = DivNumW'(gap) << FracBits;
    else div_req.num = DivNumW'(1) << (2 * FracBits);
  end

  assign sqrt_req.start    = (state_q == ST_SUM) && !sq_sum[64];
  assign sqrt_req.radicand = sq_sum[63:0];

  // The one shared multiplier.
  always_comb begin
    mul_a = a_q;
    mul_b = a_q;
    case (state_q)
      ST_EMIT: begin
        mul_a = x_first ? mag32(dir_y_q) : mag32(dir_x_q);
        mul_b = x_first ? tnx_q : tny_q;
      end
      ST_SQB: begin
        mul_a = b_q;
        mul_b = b_q;
      end
      default: begin
        mul_a = a_q;
        mul_b = a_q;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Hit position: the crossed coordinate sits on the cell boundary, the other
  // one moves along the ray by the scaled crossing time.
  assign p_oth  = vert_q ? org_y_q : org_x_q;
  assign v_oth  = vert_q ? dir_y_q : dir_x_q;
  assign d_oth  = prod_q[63:FracBits];
  assign p_ext  = {{34{p_oth[31]}}, p_oth};
  assign d_ext  = 66'(d_oth);
  assign h_oth  = sat32(v_oth[31] ? $signed(p_ext - d_ext) : $signed(p_ext + d_ext));
  assign c_crs  = vert_q ? cell_x_q : cell_y_q;
  assign s_crs  = vert_q ? sgn_x_q : sgn_y_q;
  assign inc    = (s_crs == 2'b01);
  assign c_inc  = {c_crs[CellBits-1], c_crs} + {{CellBits{1'b0}}, inc};
  assign crs_wide = 66'($signed(c_inc)) <<< FracBits;
  assign h_crs  = sat32($signed(crs_wide));
  assign c_step = c_crs + CellBits'($signed(s_crs));
  assign hx     = vert_q ? h_crs : h_oth;
  assign hy     = vert_q ? h_oth : h_crs;

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = (item_i.op == OP_START) ? ST_DIV_GO : ST_EMIT;
        end
      end
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_d = (div_idx_q == 2'd3) ? ST_EMIT : ST_DIV_GO;
      end
      ST_EMIT:     state_d = both_never ? ST_OUT : ST_POS;
      ST_POS:      state_d = ST_SQA;
      ST_SQA:      state_d = ST_SQB;
      ST_SQB:      state_d = ST_SUM;
      ST_SUM:      state_d = sq_sum[64] ? ST_OUT : ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Ray state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      tnx_q     <= Never;
      tny_q     <= Never;
      tix_q     <= Never;
      tiy_q     <= Never;
      cell_x_q  <= '0;
      cell_y_q  <= '0;
      sgn_x_q   <= 2'b00;
      sgn_y_q   <= 2'b00;
      div_idx_q <= 2'd0;
    end else begin
      if (state_q == ST_IDLE && item_valid_i) begin
        div_idx_q <= 2'd0;
        if (item_i.op == OP_START) begin
          org_x_q  <= item_i.origin_x;
          org_y_q  <= item_i.origin_y;
          dir_x_q  <= item_i.dir_x;
          dir_y_q  <= item_i.dir_y;
          cell_x_q <= CellBits'($signed(item_i.origin_x) >>> FracBits);
          cell_y_q <= CellBits'($signed(item_i.origin_y) >>> FracBits);
          sgn_x_q  <= (item_i.dir_x == '0) ? 2'b00 : (item_i.dir_x[31] ? 2'b11 : 2'b01);
          sgn_y_q  <= (item_i.dir_y == '0) ? 2'b00 : (item_i.dir_y[31] ? 2'b11 : 2'b01);
        end else if (!both_never) begin
          // Ties go to the horizontal edge.
          if (x_first) begin
            cell_x_q <= cell_x_q + CellBits'($signed(sgn_x_q));
            tnx_q    <= time_add(tnx_q, tix_q);
          end else begin
            cell_y_q <= cell_y_q + CellBits'($signed(sgn_y_q));
            tny_q    <= time_add(tny_q, tiy_q);
          end
        end
      end
      if (state_q == ST_DIV_WAIT && div_done) begin
        case (div_idx_q)
          2'd0:    tix_q <= div_quo;
          2'd1:    tnx_q <= div_quo;
          2'd2:    tiy_q <= div_quo;
          default: tny_q <= div_quo;
        endcase
        div_idx_q <= div_idx_q + 2'd1;
      end
    end
  end

  // Working registers of the hit computation.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_EMIT: begin
        vert_q <= x_first;
        prod_q <= mul_p;
        if (both_never) begin
          res_q <= '{distance: Never, no_hit: 1'b1, default: '0};
        end
      end
      ST_POS: begin
        res_q.hit_x  <= hx;
        res_q.hit_y  <= hy;
        res_q.no_hit <= 1'b0;
        res_q.offset <= frac_off(h_oth);
        if (vert_q) begin
          res_q.cell_x   <= 16'($signed(c_step));
          res_q.cell_y   <= 16'($signed(h_oth) >>> FracBits);
          res_q.edge_res <= inc ? EDGE_LEFT : EDGE_RIGHT;
        end else begin
          res_q.cell_y   <= 16'($signed(c_step));
          res_q.cell_x   <= 16'($signed(h_oth) >>> FracBits);
          res_q.edge_res <= inc ? EDGE_TOP : EDGE_BOTTOM;
        end
        a_q <= abs_diff(hx, org_x_q);
        b_q <= abs_diff(hy, org_y_q);
      end
      ST_SQA: prod_q <= mul_p;
      ST_SQB: begin
        a2_q   <= prod_q;
        prod_q <= mul_p;
      end
      ST_SUM: begin
        if (sq_sum[64]) res_q.distance <= Never;
      end
      ST_SQRT: begin
        if (sqrt_done) res_q.distance <= sqrt_root;
      end
      default: ;
    endcase
    if (out_load) out_q <= res_q;
  end

endmodule

// ===== rtl/grid_ray_traversal.sv =====
// Two-dimensional grid ray walker in signed Q16.16. A start word loads the ray
// and returns the first boundary hit; each advance word steps over the nearer
// cell boundary and returns the next hit. Input words queue two deep in front
// of the datapath, and a finished hit waits in an output register while the
// next word is already being worked on. A start word runs four serial divisions
// of 33 steps each in the shared divider, then the hit computation; an advance
// word skips the divisions and spends most of its time in the 32-step square
// root that gives the distance. A word whose ray never crosses again skips the
// hit computation.
module grid_ray_traversal import grt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] hit_x_o,
  output logic signed [31:0] hit_y_o,
  output logic signed [15:0] cell_x_o,
  output logic signed [15:0] cell_y_o,
  output logic        [1:0]  edge_res_o,
  output logic        [15:0] offset_o,
  output logic        [31:0] distance_o,
  output logic               no_hit_o
);

  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  grt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  grt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign hit_x_o    = res.hit_x;
  assign hit_y_o    = res.hit_y;
  assign cell_x_o   = res.cell_x;
  assign cell_y_o   = res.cell_y;
  assign edge_res_o = res.edge_res;
  assign offset_o   = res.offset;
  assign distance_o = res.distance;
  assign no_hit_o   = res.no_hit;

endmodule

// ===== rtl/grt_checker.sv =====
`include "grid_ray_traversal_defines.svh"

module grt_checker import grt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic [31:0] origin_x_i,
  input logic [31:0] origin_y_i,
  input logic [31:0] dir_x_i,
  input logic [31:0] dir_y_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] hit_x_o,
  input logic [31:0] hit_y_o,
  input logic [15:0] cell_x_o,
  input logic [15:0] cell_y_o,
  input logic [1:0]  edge_res_o,
  input logic [15:0] offset_o,
  input logic [31:0] distance_o,
  input logic        no_hit_o
);

  // A stalled word keeps its contents.
  `GRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(hit_x_o) && $stable(distance_o) && $stable(no_hit_o))

  // A ray without a crossing reports only the flag and the saturated distance.
  `GRT_ASSERT_NOW(a_no_hit_fields, clk_i, rst_ni, out_valid_o && no_hit_o,
    distance_o == Never && hit_x_o == '0 && hit_y_o == '0 && cell_x_o == '0 &&
    cell_y_o == '0 && offset_o == '0)

  // A horizontal edge lies on a whole row boundary unless it saturated.
  `GRT_ASSERT_NOW(a_row_boundary, clk_i, rst_ni,
    out_valid_o && !no_hit_o && (edge_res_o == EDGE_TOP || edge_res_o == EDGE_BOTTOM),
    hit_y_o[FracBits-1:0] == '0 || hit_y_o == 32'h7FFF_FFFF)

  // A vertical edge lies on a whole column boundary unless it saturated.
  `GRT_ASSERT_NOW(a_col_boundary, clk_i, rst_ni,
    out_valid_o && !no_hit_o && (edge_res_o == EDGE_LEFT || edge_res_o == EDGE_RIGHT),
    hit_x_o[FracBits-1:0] == '0 || hit_x_o == 32'h7FFF_FFFF)

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (.*);

// ===== dv/grid_ray_traversal_checker.sv =====
module grid_ray_traversal_checker import grt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               mode_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] hit_x_i,
  input  logic signed [31:0] hit_y_i,
  input  logic signed [15:0] cell_x_i,
  input  logic signed [15:0] cell_y_i,
  input  logic        [1:0]  edge_res_i,
  input  logic        [15:0] offset_i,
  input  logic        [31:0] distance_i,
  input  logic               no_hit_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 hits_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] NeverT = 32'hFFFF_FFFF;

  // Walker state, mirrored from the block.
  logic signed [31:0] org_x, org_y, vel_x, vel_y;
  logic [31:0]        t_next_x, t_next_y, t_step_x, t_step_y;
  logic [15:0]        col, row;
  int                 sgn_x, sgn_y;
  result_t            hit_fifo[$];

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] sat_time(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return NeverT;
    q = num / den;
    return q >= 64'(NeverT) ? NeverT : q[31:0];
  endfunction

  function automatic logic [31:0] acc_time(logic [31:0] t, logic [31:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {1'b0, d};
    if (t == NeverT || s >= {1'b0, NeverT}) return NeverT;
    return s[31:0];
  endfunction

  function automatic longint cell_floor(longint p);
    return longint'(p >>> 16);
  endfunction

  function automatic longint trace_along(longint p, longint v, logic [31:0] t);
    logic [63:0] d;
    d = (64'(abs64(v)) * 64'(t)) >> 16;
    return sat_s32(v < 0 ? p - longint'(d) : p + longint'(d));
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic launch_axis(input longint p, input longint v, output int sgn,
                             output logic [31:0] nxt, output logic [31:0] ivl,
                             output logic [15:0] c);
    logic [63:0] f, gap;
    f = 64'(p[15:0]);
    sgn = v > 0 ? 1 : (v < 0 ? -1 : 0);
    c = 16'(cell_floor(p));
    if (sgn == 0) begin
      nxt = NeverT;
      ivl = NeverT;
    end else begin
      ivl = sat_time(64'd1 << 32, 64'(abs64(v)));
      gap = sgn > 0 ? 64'h1_0000 - f : f;
      nxt = sat_time(gap << 16, 64'(abs64(v)));
    end
  endtask

  function automatic result_t current_hit();
    result_t r;
    logic [31:0] t;
    longint hx, hy, gx, gy, c, px, py;
    logic [63:0] a, b, a2, s, rt;
    bit vert;
    r = '0;
    if (t_next_x == NeverT && t_next_y == NeverT) begin
      r.distance = NeverT;
      r.no_hit = 1'b1;
      return r;
    end
    px = org_x;
    py = org_y;
    vert = t_next_x < t_next_y;
    t = vert ? t_next_x : t_next_y;
    if (vert) begin
      c = longint'($signed(col));
      hx = sat_s32((c + (sgn_x > 0 ? 1 : 0)) * 65536);
      hy = trace_along(py, vel_y, t);
      gx = c + sgn_x;
      gy = cell_floor(hy);
      r.edge_res = sgn_x > 0 ? EDGE_LEFT : EDGE_RIGHT;
      r.offset = hy[15:0];
    end else begin
      c = longint'($signed(row));
      hy = sat_s32((c + (sgn_y > 0 ? 1 : 0)) * 65536);
      hx = trace_along(px, vel_x, t);
      gy = c + sgn_y;
      gx = cell_floor(hx);
      r.edge_res = sgn_y > 0 ? EDGE_TOP : EDGE_BOTTOM;
      r.offset = hx[15:0];
    end
    a = 64'(abs64(hx - px));
    b = 64'(abs64(hy - py));
    a2 = a * a;
    s = a2 + b * b;
    rt = int_sqrt(s);
    r.hit_x = hx[31:0];
    r.hit_y = hy[31:0];
    r.cell_x = gx[15:0];
    r.cell_y = gy[15:0];
    r.distance = (s < a2) ? NeverT : rt[31:0];
    return r;
  endfunction

  task automatic walk_word(input logic m, input logic signed [31:0] ox,
                           input logic signed [31:0] oy, input logic signed [31:0] dx,
                           input logic signed [31:0] dy);
    if (m == OP_START) begin
      org_x = ox;
      org_y = oy;
      vel_x = dx;
      vel_y = dy;
      launch_axis(ox, dx, sgn_x, t_next_x, t_step_x, col);
      launch_axis(oy, dy, sgn_y, t_next_y, t_step_y, row);
    end else if (!(t_next_x == NeverT && t_next_y == NeverT)) begin
      if (t_next_x < t_next_y) begin
        col = 16'(col + sgn_x);
        t_next_x = acc_time(t_next_x, t_step_x);
      end else begin
        row = 16'(row + sgn_y);
        t_next_y = acc_time(t_next_y, t_step_y);
      end
    end
    hit_fifo.push_back(current_hit());
  endtask

  task automatic compare_hit();
    result_t e;
    if (hit_fifo.size() == 0) begin
      $error("hit word with nothing expected");
      errors_o++;
      return;
    end
    e = hit_fifo.pop_front();
    if (hit_x_i !== e.hit_x) begin
      $error("hit_x: expected %h, got %h", e.hit_x, hit_x_i); errors_o++;
    end
    if (hit_y_i !== e.hit_y) begin
      $error("hit_y: expected %h, got %h", e.hit_y, hit_y_i); errors_o++;
    end
    if (cell_x_i !== e.cell_x) begin
      $error("cell_x: expected %h, got %h", e.cell_x, cell_x_i); errors_o++;
    end
    if (cell_y_i !== e.cell_y) begin
      $error("cell_y: expected %h, got %h", e.cell_y, cell_y_i); errors_o++;
    end
    if (edge_res_i !== e.edge_res) begin
      $error("edge_res: expected %0d, got %0d", e.edge_res, edge_res_i); errors_o++;
    end
    if (offset_i !== e.offset) begin
      $error("offset: expected %h, got %h", e.offset, offset_i); errors_o++;
    end
    if (distance_i !== e.distance) begin
      $error("distance: expected %h, got %h", e.distance, distance_i); errors_o++;
    end
    if (no_hit_i !== e.no_hit) begin
      $error("no_hit: expected %b, got %b", e.no_hit, no_hit_i); errors_o++;
    end
  endtask

  initial begin
    errors_o = 0;
    hits_seen_o = 0;
    pending_o = 0;
    org_x = 0; org_y = 0; vel_x = 0; vel_y = 0;
    t_next_x = NeverT; t_next_y = NeverT; t_step_x = NeverT; t_step_y = NeverT;
    col = 0; row = 0; sgn_x = 0; sgn_y = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        compare_hit();
        hits_seen_o++;
      end
      if (in_valid_i && in_ready_i) walk_word(mode_i, origin_x_i, origin_y_i, dir_x_i, dir_y_i);
      pending_o = hit_fifo.size();
    end
  end

endmodule

// ===== dv/grid_ray_traversal_test.sv =====
module grid_ray_traversal_test import grt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic signed [31:0] origin_x = '0, origin_y = '0, dir_x = '0, dir_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] hit_x, hit_y;
  logic signed [15:0] cell_x, cell_y;
  logic        [1:0]  edge_res;
  logic        [15:0] offset;
  logic        [31:0] distance;
  logic               no_hit;
  int                 errors, pending, hits_seen;
  int                 send_idle_pct = 0, stall_pct = 0;
  int                 starts_sent = 0, advances_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_ray_traversal i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .mode_i(mode),
    .origin_x_i(origin_x), .origin_y_i(origin_y), .dir_x_i(dir_x), .dir_y_i(dir_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_x_o(hit_x), .hit_y_o(hit_y), .cell_x_o(cell_x), .cell_y_o(cell_y),
    .edge_res_o(edge_res), .offset_o(offset), .distance_o(distance), .no_hit_o(no_hit)
  );

  grid_ray_traversal_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .mode_i(mode),
    .origin_x_i(origin_x), .origin_y_i(origin_y), .dir_x_i(dir_x), .dir_y_i(dir_y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hit_x_i(hit_x), .hit_y_i(hit_y), .cell_x_i(cell_x), .cell_y_i(cell_y),
    .edge_res_i(edge_res), .offset_i(offset), .distance_i(distance), .no_hit_i(no_hit),
    .errors_o(errors), .pending_o(pending), .hits_seen_o(hits_seen)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Holds the word until it is taken, with a random gap in front of it.
  task automatic send_word(input op_e m, input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] dx, input logic [31:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    mode <= m;
    origin_x <= ox;
    origin_y <= oy;
    dir_x <= dx;
    dir_y <= dy;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (m == OP_START) starts_sent++;
    else advances_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(3) == 0 ? 16'h0000 : 16'($urandom()), 16'h0000};
      2: return 32'($signed($urandom_range(4000)) - 2000) << 12;
      default: return 32'($signed($urandom_range(40000)) - 20000) << 4;
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(8)) - 4);
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  initial begin
    int sent;
    int ray_len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: advance after reset, axis-aligned and diagonal rays, zero
    // vectors, rays starting on a boundary, and the field extremes.
    send_word(OP_ADVANCE, 0, 0, 0, 0);
    send_word(OP_START, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 32'h0000_0000);
    repeat (2) send_word(OP_ADVANCE, $urandom(), $urandom(), $urandom(), $urandom());
    send_word(OP_START, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    repeat (3) send_word(OP_ADVANCE, 0, 0, 0, 0);
    send_word(OP_START, 32'h1234_5678, 32'h8765_4321, 0, 0);
    send_word(OP_ADVANCE, 0, 0, 0, 0);
    send_word(OP_START, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (2) send_word(OP_ADVANCE, 0, 0, 0, 0);
    send_word(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    repeat (2) send_word(OP_ADVANCE, 0, 0, 0, 0);
    send_word(OP_START, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_START, 32'h0003_0000, 32'h0000_4000, 32'h0000_0000, 32'h0000_0100);
    repeat (2) send_word(OP_ADVANCE, 0, 0, 0, 0);

    // Random rays, each followed by a walk of random length, in idling phases.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      while (sent < (ph + 1) * 360) begin
        if ($urandom_range(19) == 0) begin
          send_word(op_e'($urandom_range(1)), $urandom(), $urandom(), $urandom(), $urandom());
          sent++;
        end else begin
          send_word(OP_START, rand_coord(), rand_coord(), rand_dir(), rand_dir());
          sent++;
          ray_len = $urandom_range(12);
          for (int k = 0; k < ray_len; k++) begin
            send_word(OP_ADVANCE, $urandom(), $urandom(), $urandom(), $urandom());
            sent++;
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d start and %0d advance words; %0d hits checked.",
             starts_sent, advances_sent, hits_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/grt_pkg.sv
rtl/grt_front.sv
rtl/grt_div.sv
rtl/grt_sqrt.sv
rtl/grt_back.sv
rtl/grid_ray_traversal.sv
rtl/grt_checker.sv
dv/grid_ray_traversal_checker.sv
dv/grid_ray_traversal_test.sv
